### rtl/djq_pkg.sv
// shared types and constants for the dma job queue with statistics
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package djq_pkg;

    localparam int CMD_W   = 2;
    localparam int SLOT_W  = 2;
    localparam int STAT_W  = 2;
    localparam int TS_W    = 32;
    localparam int CNT_W   = 32;

    localparam logic [TS_W-1:0] FIRST_LIMIT  = 32'd256;
    localparam logic [TS_W-1:0] SECOND_LIMIT = 32'd512;

    typedef enum logic [CMD_W-1:0] {
        CMD_SUBMIT = 2'd0,
        CMD_DONE   = 2'd1,
        CMD_CLEAR  = 2'd2
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        STS_OK         = 2'd0,
        STS_RING_FULL  = 2'd1,
        STS_DONE_IDLE  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_COMMIT
    } t_state;

    // sequencing commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic calc;
        logic commit;
    } t_ctl;

endpackage

`default_nettype wire

### rtl/dma_job_queue_with_stats.sv
// Dispatcher for dma transfer jobs with completion-time statistics. A command
// is taken when start is high and busy is low. Each command passes through
// the accept, a calc step for the wrapping duration subtract and the pending
// ring read, and a commit step for the queue, engine and statistics updates.
// busy is high in the calc and commit steps, so a new command can only be
// taken once the last one has committed. The result word appears on the o_
// ports in the cycle after the commit, marked by o_valid for exactly one
// cycle; it cannot be held off, so the receiver must capture it then. The
// statistics ports hold their values between results. Depends on djq_pkg,
// djq_ctrl and djq_datapath.
`timescale 1ns / 1ps
`default_nettype none

module dma_job_queue_with_stats
    import djq_pkg::*;
#(
    parameter int RING_SLOTS = 4,
    parameter int TAG_BITS   = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [CMD_W-1:0]    i_command,
    input  wire logic [SLOT_W-1:0]   i_slot,
    input  wire logic [TAG_BITS-1:0] i_job_tag,
    input  wire logic [TS_W-1:0]     i_timestamp_us,
    output logic                     o_valid,
    output logic [STAT_W-1:0]        o_status,
    output logic                     o_start_valid,
    output logic [SLOT_W-1:0]        o_start_slot,
    output logic                     o_done_valid,
    output logic [TAG_BITS-1:0]      o_done_tag,
    output logic [CNT_W-1:0]         o_xfer_count,
    output logic [TS_W-1:0]          o_duration_sum,
    output logic [TS_W-1:0]          o_duration_max,
    output logic [CNT_W-1:0]         o_over_first_limit,
    output logic [CNT_W-1:0]         o_over_second_limit
);

    t_ctl w_ctl;

    djq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_ctl   (w_ctl)
    );

    djq_datapath #(
        .RING_SLOTS (RING_SLOTS),
        .TAG_BITS   (TAG_BITS)
    ) u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_ctl               (w_ctl),
        .i_command           (i_command),
        .i_slot              (i_slot),
        .i_job_tag           (i_job_tag),
        .i_timestamp_us      (i_timestamp_us),
        .o_valid             (o_valid),
        .o_status            (o_status),
        .o_start_valid       (o_start_valid),
        .o_start_slot        (o_start_slot),
        .o_done_valid        (o_done_valid),
        .o_done_tag          (o_done_tag),
        .o_xfer_count        (o_xfer_count),
        .o_duration_sum      (o_duration_sum),
        .o_duration_max      (o_duration_max),
        .o_over_first_limit  (o_over_first_limit),
        .o_over_second_limit (o_over_second_limit)
    );

endmodule

`default_nettype wire

### rtl/djq_ctrl.sv
// sequencer for the dma job queue: accept, calculate, commit
// depends on djq_pkg
`timescale 1ns / 1ps
`default_nettype none

module djq_ctrl
    import djq_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    output logic      o_busy,
    output t_ctl      o_ctl
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_busy       = 1'b1;
        o_ctl.load   = 1'b0;
        o_ctl.calc   = 1'b0;
        o_ctl.commit = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_ctl.load = 1'b1;
                    n_state    = ST_CALC;
                end
            end
            ST_CALC: begin
                o_ctl.calc = 1'b1;
                n_state    = ST_COMMIT;
            end
            ST_COMMIT: begin
                o_ctl.commit = 1'b1;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/djq_datapath.sv
// pending ring, active job, timestamps and statistics registers
// depends on djq_pkg; sequenced by djq_ctrl
`timescale 1ns / 1ps
`default_nettype none

module djq_datapath
    import djq_pkg::*;
#(
    parameter int RING_SLOTS = 4,
    parameter int TAG_BITS   = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_ctl                i_ctl,
    input  wire logic [CMD_W-1:0]    i_command,
    input  wire logic [SLOT_W-1:0]   i_slot,
    input  wire logic [TAG_BITS-1:0] i_job_tag,
    input  wire logic [TS_W-1:0]     i_timestamp_us,
    output logic                     o_valid,
    output logic [STAT_W-1:0]        o_status,
    output logic                     o_start_valid,
    output logic [SLOT_W-1:0]        o_start_slot,
    output logic                     o_done_valid,
    output logic [TAG_BITS-1:0]      o_done_tag,
    output logic [CNT_W-1:0]         o_xfer_count,
    output logic [TS_W-1:0]          o_duration_sum,
    output logic [TS_W-1:0]          o_duration_max,
    output logic [CNT_W-1:0]         o_over_first_limit,
    output logic [CNT_W-1:0]         o_over_second_limit
);

    localparam int PTR_W = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_SLOTS - 1);

    // pending ring storage
    logic [SLOT_W-1:0]   r_ring_slot [RING_SLOTS];
    logic [TAG_BITS-1:0] r_ring_tag  [RING_SLOTS];

    // captured event
    t_cmd                r_cmd;
    logic [SLOT_W-1:0]   r_slot;
    logic [TAG_BITS-1:0] r_tag;
    logic [TS_W-1:0]     r_ts;

    // calc stage results
    logic [TS_W-1:0]     r_dt;
    logic [SLOT_W-1:0]   r_rd_slot;
    logic [TAG_BITS-1:0] r_rd_tag;

    // queue and engine state
    logic [PTR_W-1:0]    r_head, n_head;
    logic [PTR_W-1:0]    r_tail, n_tail;
    logic                r_eng_busy, n_eng_busy;
    logic [SLOT_W-1:0]   r_act_slot, n_act_slot;
    logic [TAG_BITS-1:0] r_act_tag, n_act_tag;
    logic [TS_W-1:0]     r_stamp, n_stamp;

    // statistics
    logic [CNT_W-1:0]    r_count, n_count;
    logic [TS_W-1:0]     r_sum, n_sum;
    logic [TS_W-1:0]     r_max, n_max;
    logic [CNT_W-1:0]    r_over_lo, n_over_lo;
    logic [CNT_W-1:0]    r_over_hi, n_over_hi;

    // result word
    logic                r_valid;
    t_status             r_status, n_status;
    logic                r_start_valid, n_start_valid;
    logic [SLOT_W-1:0]   r_start_slot, n_start_slot;
    logic                r_done_valid, n_done_valid;
    logic [TAG_BITS-1:0] r_done_tag, n_done_tag;

    logic                n_ring_we;
    logic [PTR_W-1:0]    w_head_nxt;
    logic [PTR_W-1:0]    w_tail_nxt;

    assign w_head_nxt = (r_head == PTR_LAST) ? '0 : r_head + 1'b1;
    assign w_tail_nxt = (r_tail == PTR_LAST) ? '0 : r_tail + 1'b1;

    // capture, duration subtract and ring read
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd  <= t_cmd'(i_command);
            r_slot <= i_slot;
            r_tag  <= i_job_tag;
            r_ts   <= i_timestamp_us;
        end
        if (i_ctl.calc) begin
            r_dt      <= r_ts - r_stamp;
            r_rd_slot <= r_ring_slot[r_head];
            r_rd_tag  <= r_ring_tag[r_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_ring_we) begin
            r_ring_slot[r_tail] <= r_slot;
            r_ring_tag[r_tail]  <= r_tag;
        end
    end

    always_comb begin
        n_head        = r_head;
        n_tail        = r_tail;
        n_eng_busy    = r_eng_busy;
        n_act_slot    = r_act_slot;
        n_act_tag     = r_act_tag;
        n_stamp       = r_stamp;
        n_count       = r_count;
        n_sum         = r_sum;
        n_max         = r_max;
        n_over_lo     = r_over_lo;
        n_over_hi     = r_over_hi;
        n_status      = STS_OK;
        n_start_valid = 1'b0;
        n_start_slot  = '0;
        n_done_valid  = 1'b0;
        n_done_tag    = '0;
        n_ring_we     = 1'b0;
        if (i_ctl.commit) begin
            unique case (r_cmd)
                CMD_SUBMIT: begin
                    if (!r_eng_busy) begin
                        n_act_slot    = r_slot;
                        n_act_tag     = r_tag;
                        n_stamp       = r_ts;
                        n_eng_busy    = 1'b1;
                        n_start_valid = 1'b1;
                        n_start_slot  = r_slot;
                    end else if (w_tail_nxt == r_head) begin
                        n_status = STS_RING_FULL;
                    end else begin
                        n_ring_we = 1'b1;
                        n_tail    = w_tail_nxt;
                    end
                end
                CMD_DONE: begin
                    if (!r_eng_busy) begin
                        n_status = STS_DONE_IDLE;
                    end else begin
                        n_count = r_count + 1'b1;
                        n_sum   = r_sum + r_dt;
                        if (r_dt > r_max) begin
                            n_max = r_dt;
                        end
                        if (r_dt > FIRST_LIMIT) begin
                            n_over_lo = r_over_lo + 1'b1;
                        end
                        if (r_dt > SECOND_LIMIT) begin
                            n_over_hi = r_over_hi + 1'b1;
                        end
                        n_done_valid = 1'b1;
                        n_done_tag   = r_act_tag;
                        // chain straight into the next pending job
                        if (r_head != r_tail) begin
                            n_act_slot    = r_rd_slot;
                            n_act_tag     = r_rd_tag;
                            n_head        = w_head_nxt;
                            n_stamp       = r_ts;
                            n_start_valid = 1'b1;
                            n_start_slot  = r_rd_slot;
                        end else begin
                            n_eng_busy = 1'b0;
                        end
                    end
                end
                CMD_CLEAR: begin
                    n_count   = '0;
                    n_sum     = '0;
                    n_max     = '0;
                    n_over_lo = '0;
                    n_over_hi = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head        <= '0;
            r_tail        <= '0;
            r_eng_busy    <= 1'b0;
            r_act_slot    <= '0;
            r_act_tag     <= '0;
            r_stamp       <= '0;
            r_count       <= '0;
            r_sum         <= '0;
            r_max         <= '0;
            r_over_lo     <= '0;
            r_over_hi     <= '0;
            r_valid       <= 1'b0;
            r_status      <= STS_OK;
            r_start_valid <= 1'b0;
            r_start_slot  <= '0;
            r_done_valid  <= 1'b0;
            r_done_tag    <= '0;
        end else begin
            r_valid <= i_ctl.commit;
            if (i_ctl.commit) begin
                r_head        <= n_head;
                r_tail        <= n_tail;
                r_eng_busy    <= n_eng_busy;
                r_act_slot    <= n_act_slot;
                r_act_tag     <= n_act_tag;
                r_stamp       <= n_stamp;
                r_count       <= n_count;
                r_sum         <= n_sum;
                r_max         <= n_max;
                r_over_lo     <= n_over_lo;
                r_over_hi     <= n_over_hi;
                r_status      <= n_status;
                r_start_valid <= n_start_valid;
                r_start_slot  <= n_start_slot;
                r_done_valid  <= n_done_valid;
                r_done_tag    <= n_done_tag;
            end
        end
    end

    assign o_valid             = r_valid;
    assign o_status            = r_status;
    assign o_start_valid       = r_start_valid;
    assign o_start_slot        = r_start_slot;
    assign o_done_valid        = r_done_valid;
    assign o_done_tag          = r_done_tag;
    assign o_xfer_count        = r_count;
    assign o_duration_sum      = r_sum;
    assign o_duration_max      = r_max;
    assign o_over_first_limit  = r_over_lo;
    assign o_over_second_limit = r_over_hi;

endmodule

`default_nettype wire

### dv/dma_job_queue_with_stats_tb.sv
// testbench for dma_job_queue_with_stats: directed and random submit, done, clear
// and unused commands, checked against an in-bench prediction of queue and statistics
// depends on djq_pkg and the dma_job_queue_with_stats rtl
`timescale 1ns / 1ps

module dma_job_queue_with_stats_tb;
    import djq_pkg::*;

    localparam int TAG_W       = 16;
    localparam int RAND_WORDS  = 1550;
    localparam int CYCLE_LIMIT = 300000;
    localparam int SETTLE      = 8;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              start_valid;
        logic [SLOT_W-1:0] start_slot;
        logic              done_valid;
        logic [TAG_W-1:0]  done_tag;
        logic [CNT_W-1:0]  xfer_count;
        logic [TS_W-1:0]   duration_sum;
        logic [TS_W-1:0]   duration_max;
        logic [CNT_W-1:0]  over_first;
        logic [CNT_W-1:0]  over_second;
    } t_result;

    class dispatch_scoreboard;
        t_result           expected_words[$];
        logic [SLOT_W-1:0] ring_slot[4];
        logic [TAG_W-1:0]  ring_tag[4];
        logic [1:0]        head;
        logic [1:0]        tail;
        logic              engine_on;
        logic [SLOT_W-1:0] cur_slot;
        logic [TAG_W-1:0]  cur_tag;
        logic [TS_W-1:0]   stamp;
        logic [CNT_W-1:0]  count;
        logic [TS_W-1:0]   sum;
        logic [TS_W-1:0]   max_dur;
        logic [CNT_W-1:0]  over1;
        logic [CNT_W-1:0]  over2;
        int errors;
        int words_in;
        int words_out;
        int started;
        int finished;
        int rejected;
        int idle_dones;
        int clears;

        function new();
            head = '0;
            tail = '0;
            engine_on = 1'b0;
            cur_slot = '0;
            cur_tag = '0;
            stamp = '0;
            count = '0;
            sum = '0;
            max_dur = '0;
            over1 = '0;
            over2 = '0;
            errors = 0;
            words_in = 0;
            words_out = 0;
            started = 0;
            finished = 0;
            rejected = 0;
            idle_dones = 0;
            clears = 0;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        // works out the result of one accepted command word
        function void predict_dispatch(logic [CMD_W-1:0] cmd, logic [SLOT_W-1:0] slot,
                                       logic [TAG_W-1:0] tag, logic [TS_W-1:0] ts);
            t_result    w;
            logic [TS_W-1:0] dt;
            logic [1:0] tail_next;
            w = '0;
            tail_next = tail + 2'd1;
            words_in++;
            case (cmd)
                CMD_SUBMIT: begin
                    if (!engine_on) begin
                        cur_slot = slot;
                        cur_tag = tag;
                        stamp = ts;
                        engine_on = 1'b1;
                        w.start_valid = 1'b1;
                        w.start_slot = slot;
                        started++;
                    end else if (tail_next == head) begin
                        w.status = STS_RING_FULL;
                        rejected++;
                    end else begin
                        ring_slot[tail] = slot;
                        ring_tag[tail] = tag;
                        tail = tail_next;
                    end
                end
                CMD_DONE: begin
                    if (!engine_on) begin
                        w.status = STS_DONE_IDLE;
                        idle_dones++;
                    end else begin
                        dt = ts - stamp;
                        count = count + 32'd1;
                        sum = sum + dt;
                        if (dt > max_dur) max_dur = dt;
                        if (dt > FIRST_LIMIT) over1 = over1 + 32'd1;
                        if (dt > SECOND_LIMIT) over2 = over2 + 32'd1;
                        w.done_valid = 1'b1;
                        w.done_tag = cur_tag;
                        finished++;
                        if (head != tail) begin
                            cur_slot = ring_slot[head];
                            cur_tag = ring_tag[head];
                            head = head + 2'd1;
                            stamp = ts;
                            w.start_valid = 1'b1;
                            w.start_slot = cur_slot;
                            started++;
                        end else begin
                            engine_on = 1'b0;
                        end
                    end
                end
                CMD_CLEAR: begin
                    count = '0;
                    sum = '0;
                    max_dur = '0;
                    over1 = '0;
                    over2 = '0;
                    clears++;
                end
                default: ;
            endcase
            w.xfer_count = count;
            w.duration_sum = sum;
            w.duration_max = max_dur;
            w.over_first = over1;
            w.over_second = over2;
            expected_words.push_back(w);
        endfunction

        task report(string what, logic [31:0] exp_v, logic [31:0] got_v);
            $display("mismatch at result %0d: %s expected 0x%0h got 0x%0h",
                     words_out, what, exp_v, got_v);
            errors++;
        endtask

        task check_word(t_result got);
            t_result e;
            if (expected_words.size() == 0) begin
                report("unexpected result word", '0, 32'(got.status));
            end else begin
                e = expected_words.pop_front();
                if (got.status !== e.status)
                    report("status", 32'(e.status), 32'(got.status));
                if (got.start_valid !== e.start_valid)
                    report("start_valid", 32'(e.start_valid), 32'(got.start_valid));
                if (got.start_slot !== e.start_slot)
                    report("start_slot", 32'(e.start_slot), 32'(got.start_slot));
                if (got.done_valid !== e.done_valid)
                    report("done_valid", 32'(e.done_valid), 32'(got.done_valid));
                if (got.done_tag !== e.done_tag)
                    report("done_tag", 32'(e.done_tag), 32'(got.done_tag));
                if (got.xfer_count !== e.xfer_count)
                    report("xfer_count", e.xfer_count, got.xfer_count);
                if (got.duration_sum !== e.duration_sum)
                    report("duration_sum", e.duration_sum, got.duration_sum);
                if (got.duration_max !== e.duration_max)
                    report("duration_max", e.duration_max, got.duration_max);
                if (got.over_first !== e.over_first)
                    report("over_first_limit", e.over_first, got.over_first);
                if (got.over_second !== e.over_second)
                    report("over_second_limit", e.over_second, got.over_second);
            end
            words_out++;
        endtask
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [CMD_W-1:0]  i_command = '0;
    logic [SLOT_W-1:0] i_slot = '0;
    logic [TAG_W-1:0]  i_job_tag = '0;
    logic [TS_W-1:0]   i_timestamp_us = '0;
    logic              o_valid;
    logic [STAT_W-1:0] o_status;
    logic              o_start_valid;
    logic [SLOT_W-1:0] o_start_slot;
    logic              o_done_valid;
    logic [TAG_W-1:0]  o_done_tag;
    logic [CNT_W-1:0]  o_xfer_count;
    logic [TS_W-1:0]   o_duration_sum;
    logic [TS_W-1:0]   o_duration_max;
    logic [CNT_W-1:0]  o_over_first_limit;
    logic [CNT_W-1:0]  o_over_second_limit;

    dispatch_scoreboard sb;
    int cycles = 0;
    logic [TS_W-1:0] now_us;

    dma_job_queue_with_stats #(
        .RING_SLOTS(4),
        .TAG_BITS(TAG_W)
    ) DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_command          (i_command),
        .i_slot             (i_slot),
        .i_job_tag          (i_job_tag),
        .i_timestamp_us     (i_timestamp_us),
        .o_valid            (o_valid),
        .o_status           (o_status),
        .o_start_valid      (o_start_valid),
        .o_start_slot       (o_start_slot),
        .o_done_valid       (o_done_valid),
        .o_done_tag         (o_done_tag),
        .o_xfer_count       (o_xfer_count),
        .o_duration_sum     (o_duration_sum),
        .o_duration_max     (o_duration_max),
        .o_over_first_limit (o_over_first_limit),
        .o_over_second_limit(o_over_second_limit)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("dma_job_queue_with_stats_tb NOT OK");
            $finish;
        end
    end

    // result first: it always belongs to an older word than one accepted at this edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) begin
                sb.check_word('{o_status, o_start_valid, o_start_slot, o_done_valid,
                                o_done_tag, o_xfer_count, o_duration_sum, o_duration_max,
                                o_over_first_limit, o_over_second_limit});
            end
            if (start && !busy) sb.predict_dispatch(i_command, i_slot, i_job_tag,
                                                    i_timestamp_us);
        end
    end

    // gap idle cycles, then hold the word until the block takes it
    task automatic send_word(logic [CMD_W-1:0] cmd, logic [SLOT_W-1:0] slot,
                             logic [TAG_W-1:0] tag, logic [TS_W-1:0] ts, int gap);
        repeat (gap) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start <= 1'b1;
        i_command <= cmd;
        i_slot <= slot;
        i_job_tag <= tag;
        i_timestamp_us <= ts;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic run_directed();
        send_word(CMD_DONE,   2'd0, 16'h0000, 32'h0000_0000, 0);
        send_word(CMD_UNUSED, 2'd3, 16'hffff, 32'hffff_ffff, 0);
        send_word(CMD_CLEAR,  2'd0, 16'h0000, 32'h0000_0000, 1);
        send_word(CMD_SUBMIT, 2'd0, 16'h0000, 32'h0000_0000, 0);
        send_word(CMD_SUBMIT, 2'd1, 16'hffff, 32'h0000_0005, 0);
        send_word(CMD_SUBMIT, 2'd2, 16'h8001, 32'h0000_0006, 2);
        send_word(CMD_SUBMIT, 2'd3, 16'h1234, 32'h0000_0007, 0);
        // ring holds three pending jobs, so this one bounces
        send_word(CMD_SUBMIT, 2'd3, 16'haaaa, 32'h0000_0008, 0);
        send_word(CMD_DONE,   2'd0, 16'h0000, 32'hffff_ffff, 0);
        // timestamp wrapped: 257 us, sum wraps too
        send_word(CMD_DONE,   2'd0, 16'h0000, 32'h0000_0100, 3);
        send_word(CMD_DONE,   2'd0, 16'h0000, 32'h0000_0200, 0);
        send_word(CMD_CLEAR,  2'd1, 16'h5a5a, 32'h0000_0300, 0);
        send_word(CMD_DONE,   2'd0, 16'h0000, 32'h0000_0400, 0);
        send_word(CMD_SUBMIT, 2'd2, 16'h5555, 32'h0000_1000, 0);
        send_word(CMD_DONE,   2'd0, 16'h0000, 32'h0000_1201, 0);
        send_word(CMD_DONE,   2'd0, 16'h0000, 32'h0000_1300, 0);
        send_word(CMD_SUBMIT, 2'd1, 16'h00ff, 32'h7fff_ffff, 0);
        send_word(CMD_DONE,   2'd0, 16'h0000, 32'h8000_0000, 0);
        send_word(CMD_UNUSED, 2'd0, 16'h0000, 32'h0000_0000, 0);
        drain_results();
    endtask

    task automatic run_random();
        int sent;
        int seg_len;
        int sub_pct;
        int done_pct;
        int roll;
        bit no_gaps;
        logic [CMD_W-1:0] cmd;
        logic [TS_W-1:0]  ts;
        logic [TAG_W-1:0] tag;
        sent = 0;
        now_us = $urandom;
        while (sent < RAND_WORDS) begin
            seg_len = $urandom_range(5, 40);
            no_gaps = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 2))
                0: begin sub_pct = 75; done_pct = 17; end  // fills the ring
                1: begin sub_pct = 25; done_pct = 67; end  // empties it
                default: begin sub_pct = 48; done_pct = 44; end
            endcase
            repeat (seg_len) begin
                roll = $urandom_range(0, 99);
                if (roll < sub_pct) cmd = CMD_SUBMIT;
                else if (roll < sub_pct + done_pct) cmd = CMD_DONE;
                else if (roll < sub_pct + done_pct + 5) cmd = CMD_CLEAR;
                else cmd = CMD_UNUSED;
                now_us = now_us + $urandom_range(0, 800);
                ts = ($urandom_range(0, 31) == 0) ? $urandom : now_us;
                case ($urandom_range(0, 9))
                    0: tag = '0;
                    1: tag = '1;
                    default: tag = TAG_W'($urandom_range(0, 65535));
                endcase
                send_word(cmd, SLOT_W'($urandom_range(0, 3)), tag, ts,
                          no_gaps ? 0 : $urandom_range(0, 17));
                sent++;
            end
            if ($urandom_range(0, 9) == 0) drain_results();
        end
    endtask

    initial begin
        sb = new();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        run_random();
        drain_results();
        repeat (SETTLE) @(posedge i_clk);
        $display("covered %0d words: %0d jobs started, %0d completed, %0d rejected",
                 sb.words_in, sb.started, sb.finished, sb.rejected);
        $display("%0d done events while idle, %0d clears, %0d result words checked",
                 sb.idle_dones, sb.clears, sb.words_out);
        if (sb.errors == 0) begin
            $display("dma_job_queue_with_stats_tb OK");
        end else begin
            $display("dma_job_queue_with_stats_tb NOT OK");
        end
        $finish;
    end

endmodule

### files.f
rtl/djq_pkg.sv
rtl/djq_ctrl.sv
rtl/djq_datapath.sv
rtl/dma_job_queue_with_stats.sv
dv/dma_job_queue_with_stats_tb.sv
